// ----- hdl/thermistor_median_temperature_assert.svh -----
// assertion macros for the thermistor median temperature block
`ifndef THERMISTOR_MEDIAN_TEMPERATURE_ASSERT_SVH
`define THERMISTOR_MEDIAN_TEMPERATURE_ASSERT_SVH

// same-cycle implication, clocked on clk, off while in reset
`define TMT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tmt assertion failed");

// next-cycle implication, clocked on clk, off while in reset
`define TMT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tmt assertion failed");

`endif

// ----- hdl/tmt_pkg.sv -----
// shared types, constants and resistance table for the thermistor block
package tmt_pkg;

	localparam int TMT_WINDOW_LENGTH = 5;
	localparam int TMT_TABLE_DEPTH   = 90;

	localparam int SAMPLE_W   = 12;
	localparam int NUM_W      = 20;
	localparam int RES_W      = 16;
	localparam int TEMP_W     = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int ROM_ADDR_W = 8;
	localparam int ROM_STORED = 90;

	localparam logic [CFG_IDX_W-1:0] CFG_DIV_NUM   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RES_OFF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OPEN_THR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TOP_TEMP  = 3'd4;

	localparam logic [NUM_W-1:0]    RST_DIV_NUM   = 20'd409600;
	localparam logic [RES_W-1:0]    RST_RES_OFF   = 16'd100;
	localparam logic [SAMPLE_W-1:0] RST_LOW_LIMIT = 12'd10;
	localparam logic [RES_W-1:0]    RST_OPEN_THR  = 16'd300;
	localparam logic [TEMP_W-1:0]   RST_TOP_TEMP  = 8'd100;

	typedef struct packed {
		logic [NUM_W-1:0]    div_num;
		logic [RES_W-1:0]    res_off;
		logic [SAMPLE_W-1:0] low_limit;
		logic [RES_W-1:0]    open_thr;
		logic [TEMP_W-1:0]   top_temp;
	} cfg_t;

	typedef struct packed {
		logic load;
		logic med_step;
		logic div_start;
		logic div_step;
		logic res_calc;
		logic search_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic med_last;
		logic med_ok;
		logic div_last;
		logic res_go;
		logic search_hit;
		logic out_free;
	} stat_t;

	function automatic logic [RES_W-1:0] rom_entry(input logic [ROM_ADDR_W-1:0] n);
		logic [RES_W-1:0] r;
		case (n)
			8'd0:  r = 16'd740;   8'd1:  r = 16'd742;   8'd2:  r = 16'd743;
			8'd3:  r = 16'd745;   8'd4:  r = 16'd750;   8'd5:  r = 16'd755;
			8'd6:  r = 16'd760;   8'd7:  r = 16'd790;   8'd8:  r = 16'd820;
			8'd9:  r = 16'd850;   8'd10: r = 16'd880;   8'd11: r = 16'd885;
			8'd12: r = 16'd890;   8'd13: r = 16'd895;   8'd14: r = 16'd900;
			8'd15: r = 16'd918;   8'd16: r = 16'd936;   8'd17: r = 16'd954;
			8'd18: r = 16'd972;   8'd19: r = 16'd990;   8'd20: r = 16'd1200;
			8'd21: r = 16'd1250;  8'd22: r = 16'd1300;  8'd23: r = 16'd1350;
			8'd24: r = 16'd1400;  8'd25: r = 16'd1450;  8'd26: r = 16'd1500;
			8'd27: r = 16'd1550;  8'd28: r = 16'd1600;  8'd29: r = 16'd1650;
			8'd30: r = 16'd1700;  8'd31: r = 16'd1750;  8'd32: r = 16'd1800;
			8'd33: r = 16'd1880;  8'd34: r = 16'd1960;  8'd35: r = 16'd2040;
			8'd36: r = 16'd2120;  8'd37: r = 16'd2200;  8'd38: r = 16'd2300;
			8'd39: r = 16'd2400;  8'd40: r = 16'd2500;  8'd41: r = 16'd2600;
			8'd42: r = 16'd2700;  8'd43: r = 16'd2800;  8'd44: r = 16'd2900;
			8'd45: r = 16'd3000;  8'd46: r = 16'd3180;  8'd47: r = 16'd3270;
			8'd48: r = 16'd3360;  8'd49: r = 16'd3560;  8'd50: r = 16'd3730;
			8'd51: r = 16'd3910;  8'd52: r = 16'd4100;  8'd53: r = 16'd4250;
			8'd54: r = 16'd4400;  8'd55: r = 16'd4550;  8'd56: r = 16'd4700;
			8'd57: r = 16'd4850;  8'd58: r = 16'd5000;  8'd59: r = 16'd5600;
			8'd60: r = 16'd6200;  8'd61: r = 16'd6300;  8'd62: r = 16'd6400;
			8'd63: r = 16'd6500;  8'd64: r = 16'd6850;  8'd65: r = 16'd7120;
			8'd66: r = 16'd7580;  8'd67: r = 16'd7960;  8'd68: r = 16'd8340;
			8'd69: r = 16'd8710;  8'd70: r = 16'd9100;  8'd71: r = 16'd10400;
			8'd72: r = 16'd11700; 8'd73: r = 16'd13000; 8'd74: r = 16'd14400;
			8'd75: r = 16'd15800; 8'd76: r = 16'd17200; 8'd77: r = 16'd18600;
			8'd78: r = 16'd20000; 8'd79: r = 16'd21400; 8'd80: r = 16'd23000;
			8'd81: r = 16'd25000; 8'd82: r = 16'd28000; 8'd83: r = 16'd31000;
			8'd84: r = 16'd35000; 8'd85: r = 16'd38000; 8'd86: r = 16'd41000;
			8'd87: r = 16'd46000; 8'd88: r = 16'd51000; 8'd89: r = 16'd56000;
			default: r = 16'hFFFF;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/tmt_ctrl.sv -----
// sequencer for median, division, resistance and table search steps
module tmt_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  tmt_pkg::stat_t  stat,
	output tmt_pkg::cmd_t   cmd
);
	import tmt_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEDIAN,
		ST_CHECK,
		ST_DIVIDE,
		ST_RESIST,
		ST_SEARCH,
		ST_DONE
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_ready_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready_q) begin
					cmd.load = 1'b1;
					state_d  = ST_MEDIAN;
				end
			end
			ST_MEDIAN: begin
				cmd.med_step = 1'b1;
				if (stat.med_last) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				// a median at or below the limit skips the division
				if (stat.med_ok) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIVIDE;
				end else begin
					state_d = ST_RESIST;
				end
			end
			ST_DIVIDE: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = ST_RESIST;
				end
			end
			ST_RESIST: begin
				cmd.res_calc = 1'b1;
				state_d      = stat.res_go ? ST_SEARCH : ST_DONE;
			end
			ST_SEARCH: begin
				cmd.search_step = 1'b1;
				if (stat.search_hit) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_ready_q <= 1'b1;
		end else begin
			state_q    <= state_d;
			in_ready_q <= (state_d == ST_IDLE);
		end
	end

	assign in_ready = in_ready_q;

endmodule

// ----- hdl/tmt_dp.sv -----
// sample window, median rank unit, restoring divider, table search and result register
module tmt_dp #(
	parameter int WINDOW_LENGTH = tmt_pkg::TMT_WINDOW_LENGTH,
	parameter int TABLE_DEPTH   = tmt_pkg::TMT_TABLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  tmt_pkg::cfg_t                    cfg,
	input  tmt_pkg::cmd_t                    cmd,
	output tmt_pkg::stat_t                   stat,
	input  logic [tmt_pkg::SAMPLE_W-1:0]     adc_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tmt_pkg::TEMP_W-1:0]       temperature,
	output logic [tmt_pkg::RES_W-1:0]        resistance,
	output logic [tmt_pkg::SAMPLE_W-1:0]     median_sample
);
	import tmt_pkg::*;

	localparam int MED_IDX_W = $clog2(WINDOW_LENGTH);
	localparam int RANK_W    = $clog2(WINDOW_LENGTH);
	localparam int DIV_CNT_W = $clog2(NUM_W);
	localparam int N_W       = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W     = $clog2(TABLE_DEPTH);

	logic [SAMPLE_W-1:0]  win_q [WINDOW_LENGTH];
	logic [MED_IDX_W-1:0] med_idx_q;
	logic [SAMPLE_W-1:0]  med_q;
	logic [SAMPLE_W-1:0]  cand;
	logic [RANK_W-1:0]    rank;

	logic [NUM_W-1:0]     quo_q;
	logic [SAMPLE_W-1:0]  rem_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [SAMPLE_W:0]    trial;
	logic                 trial_ge;

	logic [NUM_W-1:0]     q_eff;
	logic [NUM_W-1:0]     diff;
	logic [RES_W-1:0]     res_d;
	logic [RES_W-1:0]     res_q;
	logic                 go_q;

	logic [N_W-1:0]       n_q;
	logic [RES_W-1:0]     rom_val;
	logic [TEMP_W-1:0]    temp_d;

	logic                 out_valid_q;
	logic [TEMP_W-1:0]    temp_out_q;
	logic [RES_W-1:0]     res_out_q;
	logic [SAMPLE_W-1:0]  med_out_q;

	// median: candidate whose stable descending rank is the middle one
	always_comb begin
		cand = win_q[med_idx_q];
		rank = '0;
		for (int j = 0; j < WINDOW_LENGTH; j++) begin
			if ((win_q[j] > cand) || ((win_q[j] == cand) && (MED_IDX_W'(j) < med_idx_q))) begin
				rank = rank + RANK_W'(1);
			end
		end
	end

	// one quotient bit a cycle
	assign trial    = {rem_q, quo_q[NUM_W-1]};
	assign trial_ge = (trial >= {1'b0, med_q});

	always_comb begin
		q_eff = stat.med_ok ? quo_q : '0;
		diff  = q_eff - NUM_W'(cfg.res_off);
		if (q_eff <= NUM_W'(cfg.res_off)) begin
			res_d = '0;
		end else if (diff > NUM_W'({RES_W{1'b1}})) begin
			res_d = '1;
		end else begin
			res_d = diff[RES_W-1:0];
		end
	end

	assign rom_val = rom_entry(ROM_ADDR_W'(n_q[IDX_W-1:0]));

	always_comb begin
		if (!go_q || (16'(n_q) > 16'(cfg.top_temp))) begin
			temp_d = '0;
		end else begin
			temp_d = TEMP_W'(16'(cfg.top_temp) - 16'(n_q));
		end
	end

	assign stat.med_last   = (med_idx_q == MED_IDX_W'(WINDOW_LENGTH - 1));
	assign stat.med_ok     = (med_q > cfg.low_limit) && (med_q != '0);
	assign stat.div_last   = (div_cnt_q == DIV_CNT_W'(NUM_W - 1));
	assign stat.res_go     = (res_d != '0) && (res_d >= cfg.open_thr);
	assign stat.search_hit = (n_q == N_W'(TABLE_DEPTH)) || (rom_val > res_q);
	assign stat.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LENGTH; i++) begin
				win_q[i] <= '0;
			end
		end else if (cmd.load) begin
			for (int i = WINDOW_LENGTH - 1; i > 0; i--) begin
				win_q[i] <= win_q[i-1];
			end
			win_q[0] <= adc_sample;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			med_idx_q <= '0;
		end else if (cmd.med_step) begin
			if (rank == RANK_W'(WINDOW_LENGTH / 2)) begin
				med_q <= cand;
			end
			med_idx_q <= med_idx_q + MED_IDX_W'(1);
		end

		if (cmd.div_start) begin
			quo_q     <= cfg.div_num;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q     <= trial_ge ? SAMPLE_W'(trial - {1'b0, med_q}) : trial[SAMPLE_W-1:0];
			quo_q     <= {quo_q[NUM_W-2:0], trial_ge};
			div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
		end

		if (cmd.res_calc) begin
			res_q <= res_d;
			go_q  <= stat.res_go;
			n_q   <= '0;
		end else if (cmd.search_step && !stat.search_hit) begin
			n_q <= n_q + N_W'(1);
		end

		if (cmd.out_load) begin
			temp_out_q <= temp_d;
			res_out_q  <= res_q;
			med_out_q  <= med_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign temperature   = temp_out_q;
	assign resistance    = res_out_q;
	assign median_sample = med_out_q;

endmodule

// ----- hdl/thermistor_median_temperature.sv -----
// steps from accept to result valid: median rank pass over the window, restoring divider,
// then a table search of one entry a cycle that stops at the first entry above the resistance;
// the search is skipped when the resistance is zero or below the open threshold
// a new sample is taken only after the result is loaded; a finished result waits until the output register is free
// reset: asynchronous, clears the window to zero and loads the register defaults
module thermistor_median_temperature #(
	parameter int WINDOW_LENGTH = tmt_pkg::TMT_WINDOW_LENGTH,
	parameter int TABLE_DEPTH   = tmt_pkg::TMT_TABLE_DEPTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [tmt_pkg::SAMPLE_W-1:0]     adc_sample,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [tmt_pkg::TEMP_W-1:0]       temperature,
	output logic [tmt_pkg::RES_W-1:0]        resistance,
	output logic [tmt_pkg::SAMPLE_W-1:0]     median_sample,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [tmt_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmt_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tmt_pkg::*;

	`include "thermistor_median_temperature_assert.svh"

	cfg_t  cfg_q;
	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.div_num   <= RST_DIV_NUM;
			cfg_q.res_off   <= RST_RES_OFF;
			cfg_q.low_limit <= RST_LOW_LIMIT;
			cfg_q.open_thr  <= RST_OPEN_THR;
			cfg_q.top_temp  <= RST_TOP_TEMP;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_DIV_NUM:   cfg_q.div_num   <= cfg_data;
				CFG_RES_OFF:   cfg_q.res_off   <= cfg_data[RES_W-1:0];
				CFG_LOW_LIMIT: cfg_q.low_limit <= cfg_data[SAMPLE_W-1:0];
				CFG_OPEN_THR:  cfg_q.open_thr  <= cfg_data[RES_W-1:0];
				CFG_TOP_TEMP:  cfg_q.top_temp  <= cfg_data[TEMP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tmt_dp #(
		.WINDOW_LENGTH (WINDOW_LENGTH),
		.TABLE_DEPTH   (TABLE_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.cmd           (cmd),
		.stat          (stat),
		.adc_sample    (adc_sample),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.temperature   (temperature),
		.resistance    (resistance),
		.median_sample (median_sample)
	);

	// busy once an item is taken
	`TMT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// low or open resistance always reports zero temperature
	`TMT_ASSERT_IMP(a_open_gives_zero, out_valid && (resistance < cfg_q.open_thr || resistance == '0), temperature == '0)
	// a nonzero resistance needs a median above the low limit
	`TMT_ASSERT_IMP(a_res_needs_median, out_valid && resistance != '0, median_sample > cfg_q.low_limit)
	`TMT_ASSERT_IMP(a_temp_below_top, out_valid, temperature <= cfg_q.top_temp)

endmodule
